### rtl/chf_pkg.sv
// Shared types, constants and helpers for the compass heading filter.
`default_nettype none

package chf_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int RAW_BITS  = 16;
  localparam int TIME_W    = 32;
  localparam int FRAC_BITS = 8;

  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd2;

  localparam int WEIGHT_W = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 16'd32768;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd4915;
  localparam logic [CFG_W-1:0]    INTERVAL_RESET = 16'd100;

  // radix-4 shift-add multiply over the weight
  localparam int DIGIT_W     = 2;
  localparam int MUL_DIGITS  = WEIGHT_W / DIGIT_W;
  localparam int ROUND_SHIFT = 15;
  localparam int ROUND_HALF  = 16384;

  // angles in 1/16384 degree
  localparam int ANGLE_W      = 24;
  localparam int ANGLE_SHIFT  = 8;
  localparam int ANGLE_ROUND  = 128;
  localparam int HALF_TURN_FINE = 2949120;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_W       = $clog2(ATAN_ENTRIES);

  localparam logic signed [ANGLE_W-1:0] ATAN_FINE [ATAN_ENTRIES] = '{
    24'sd737280, 24'sd435242, 24'sd229970, 24'sd116736,
    24'sd58595,  24'sd29326,  24'sd14667,  24'sd7334,
    24'sd3667,   24'sd1833,   24'sd917,    24'sd458,
    24'sd229,    24'sd115,    24'sd57,     24'sd29,
    24'sd14,     24'sd7,      24'sd4,      24'sd2,
    24'sd1,      24'sd0,      24'sd0,      24'sd0
  };

  localparam int HEAD_W       = 15;
  localparam int SECTOR_W     = 3;
  localparam int FULL_TURN    = 23040;
  localparam int SECTOR_FIRST = 1440;
  localparam int SECTOR_SPAN  = 2880;
  localparam int SECTOR_WRAP  = 21600;
  localparam int SECTOR_INNER = 6;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMA,
    ST_CORDIC,
    ST_DONE
  } chf_state_t;

  typedef enum logic [1:0] {
    EMA_IDLE,
    EMA_PREP,
    EMA_MUL,
    EMA_FIN
  } ema_state_t;

  typedef enum logic [1:0] {
    CD_IDLE,
    CD_ROT,
    CD_FIN
  } cordic_state_t;

  function automatic logic [SECTOR_W-1:0] sector_of(input logic [HEAD_W-1:0] h);
    logic [SECTOR_W-1:0] s;
    s = '0;
    if (h >= HEAD_W'(SECTOR_FIRST) && h < HEAD_W'(SECTOR_WRAP)) begin
      s = SECTOR_W'(1);
      for (int k = 1; k <= SECTOR_INNER; k++) begin
        if (h >= HEAD_W'(SECTOR_FIRST + k * SECTOR_SPAN)) begin
          s = s + SECTOR_W'(1);
        end
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/chf_ema.sv
// One smoothing lane: seed or moving-average update by a radix-4 serial multiply.
`default_nettype none

module chf_ema
  import chf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    go,
  input  logic                                    seed,
  input  logic [RAW_BITS-1:0]                     raw,
  input  logic [WEIGHT_W-1:0]                     weight,
  output logic                                    busy,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] value
);

  localparam int MW    = SAMPLE_BITS + FRAC_BITS;
  localparam int RAW_W = (SAMPLE_BITS > RAW_BITS) ? SAMPLE_BITS : RAW_BITS;
  localparam int DW    = MW + 1;
  localparam int D3W   = DW + 2;
  localparam int PW    = DW + WEIGHT_W;
  localparam int RW    = PW - ROUND_SHIFT;
  localparam int CNT_W = $clog2(MUL_DIGITS);

  ema_state_t state, state_next;

  logic [RAW_W-1:0]          raw_ext;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [MW-1:0]      target;
  logic [WEIGHT_W-1:0]       w_clamp;
  logic signed [DW-1:0]      d;
  logic signed [D3W-1:0]     d3;
  logic signed [PW-1:0]      acc;
  logic signed [PW-1:0]      pick;
  logic signed [PW-1:0]      rnd;
  logic signed [RW-1:0]      step_val;
  logic [WEIGHT_W-1:0]       wsh;
  logic [CNT_W-1:0]          cnt;
  logic                      prep_en;
  logic                      mul_en;
  logic                      fin_en;

  assign raw_ext  = RAW_W'(raw);
  assign sample   = signed'(raw_ext[SAMPLE_BITS-1:0]);
  assign target   = MW'(sample) <<< FRAC_BITS;
  assign w_clamp  = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
  assign rnd      = acc + PW'(ROUND_HALF);
  assign step_val = RW'(rnd >>> ROUND_SHIFT);

  always_comb begin
    case (wsh[WEIGHT_W-1 -: DIGIT_W])
      2'd0:    pick = '0;
      2'd1:    pick = PW'(d);
      2'd2:    pick = PW'(d) <<< 1;
      default: pick = PW'(d3);
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      EMA_IDLE: if (go && !seed) state_next = EMA_PREP;
      EMA_PREP: state_next = EMA_MUL;
      EMA_MUL:  if (cnt == CNT_W'(MUL_DIGITS - 1)) state_next = EMA_FIN;
      EMA_FIN:  state_next = EMA_IDLE;
      default:  state_next = EMA_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    prep_en = 1'b0;
    mul_en  = 1'b0;
    fin_en  = 1'b0;
    case (state)
      EMA_IDLE: busy    = 1'b0;
      EMA_PREP: prep_en = 1'b1;
      EMA_MUL:  mul_en  = 1'b1;
      EMA_FIN:  fin_en  = 1'b1;
      default:  busy    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EMA_IDLE;
      value <= '0;
    end else begin
      state <= state_next;
      if (go && seed) begin
        value <= target;
      end else if (fin_en) begin
        value <= MW'(RW'(value) + step_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !seed) begin
      d   <= DW'(target) - DW'(value);
      wsh <= w_clamp;
    end
    if (prep_en) begin
      d3  <= D3W'(d) + (D3W'(d) <<< 1);
      acc <= '0;
      cnt <= '0;
    end
    if (mul_en) begin
      acc <= (acc <<< DIGIT_W) + pick;
      wsh <= wsh << DIGIT_W;
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/chf_cordic.sv
// Iterative vectoring CORDIC: atan2 of the smoothed vector to heading and sector.
`default_nettype none

module chf_cordic
  import chf_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [SAMPLE_BITS+FRAC_BITS-1:0] x_in,
  input  logic signed [SAMPLE_BITS+FRAC_BITS-1:0] y_in,
  output logic                                    busy,
  output logic [HEAD_W-1:0]                       heading,
  output logic [SECTOR_W-1:0]                     sector
);

  localparam int MW   = SAMPLE_BITS + FRAC_BITS;
  localparam int CW   = MW + 2;
  localparam int HZ_W = ANGLE_W - ANGLE_SHIFT;

  cordic_state_t state, state_next;

  logic signed [CW-1:0]      x;
  logic signed [CW-1:0]      y;
  logic signed [ANGLE_W-1:0] z;
  logic [STEP_W-1:0]         step;
  logic                      zero;
  logic                      neg;
  logic signed [CW-1:0]      dx;
  logic signed [CW-1:0]      dy;
  logic signed [ANGLE_W-1:0] a;
  logic signed [ANGLE_W-1:0] zr;
  logic signed [HZ_W-1:0]    hz;
  logic signed [HZ_W-1:0]    hw;
  logic [HEAD_W-1:0]         hsel;
  logic                      rot_en;
  logic                      fin_en;

  assign neg  = x_in[MW-1];
  assign dx   = y >>> step;
  assign dy   = x >>> step;
  assign a    = ATAN_FINE[step];
  assign zr   = z + ANGLE_W'(ANGLE_ROUND);
  assign hz   = HZ_W'(zr >>> ANGLE_SHIFT);
  assign hw   = hz[HZ_W-1] ? hz + HZ_W'(FULL_TURN) : hz;
  assign hsel = zero ? '0 : HEAD_W'(hw);

  always_comb begin
    state_next = state;
    case (state)
      CD_IDLE: if (start) state_next = CD_ROT;
      CD_ROT:  if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = CD_FIN;
      CD_FIN:  state_next = CD_IDLE;
      default: state_next = CD_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    rot_en = 1'b0;
    fin_en = 1'b0;
    case (state)
      CD_IDLE: busy   = 1'b0;
      CD_ROT:  rot_en = 1'b1;
      CD_FIN:  fin_en = 1'b1;
      default: busy   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      x    <= neg ? -CW'(x_in) : CW'(x_in);
      y    <= neg ? -CW'(y_in) : CW'(y_in);
      z    <= neg ? ANGLE_W'(HALF_TURN_FINE) : '0;
      zero <= (x_in == '0) && (y_in == '0);
      step <= '0;
    end
    if (rot_en) begin
      if (y > 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + a;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - a;
      end
      step <= step + STEP_W'(1);
    end
    if (fin_en) begin
      heading <= hsel;
      sector  <= sector_of(hsel);
    end
  end

endmodule

`default_nettype wire

### rtl/compass_heading_filter.sv
// Top level of the compass heading filter: config, rate gate, smoothing lanes, CORDIC.
// An updating transaction passes through the smoothing lanes and then the CORDIC before
// it reaches the output (a seeding one skips the weight multiply); a non-updating one goes straight to output.
// One input at a time: a new input is taken only once the previous result is loaded,
// so the radix-4 weight multiply, the CORDIC iterations and output stalls hold the flow.
// Reset (rst, synchronous) clears smoothed values, seed flag, last time and held heading.
`default_nettype none

module compass_heading_filter
  import chf_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // time_ms[31:0], mag_x[47:32], mag_y[63:48]
  input  logic                   s_tuser,   // read_ok
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // heading[14:0], sector[17:15], zero pad
  output logic                   m_tuser    // updated
);

  localparam int MW    = SAMPLE_BITS + FRAC_BITS;
  localparam int PAD_W = OUT_TDATA_W - HEAD_W - SECTOR_W;

  chf_state_t state, state_next;

  logic                  enable;
  logic [WEIGHT_W-1:0]   weight;
  logic [CFG_W-1:0]      min_interval;
  logic [TIME_W-1:0]     last_time;
  logic                  seeded;
  logic [HEAD_W-1:0]     held_heading;
  logic [SECTOR_W-1:0]   held_sector;
  logic                  updated;

  logic [TIME_W-1:0]     now;
  logic [TIME_W-1:0]     elapsed;
  logic                  in_xact;
  logic                  time_ok;
  logic                  do_update;
  logic                  ema_go;
  logic                  cordic_go;
  logic                  hold_load;
  logic                  out_load;

  logic                  ema_busy_x;
  logic                  ema_busy_y;
  logic signed [MW-1:0]  smooth_x;
  logic signed [MW-1:0]  smooth_y;
  logic                  cordic_busy;
  logic [HEAD_W-1:0]     cd_heading;
  logic [SECTOR_W-1:0]   cd_sector;

  assign now       = s_tdata[TIME_W-1:0];
  assign elapsed   = now - last_time;
  assign in_xact   = s_tvalid && s_tready;
  assign time_ok   = enable && (elapsed >= TIME_W'(min_interval));
  assign do_update = time_ok && s_tuser;
  assign ema_go    = in_xact && do_update;

  chf_ema #(.SAMPLE_BITS(SAMPLE_BITS)) u_ema_x (
    .clk    (clk),
    .rst    (rst),
    .go     (ema_go),
    .seed   (!seeded),
    .raw    (s_tdata[TIME_W +: RAW_BITS]),
    .weight (weight),
    .busy   (ema_busy_x),
    .value  (smooth_x)
  );

  chf_ema #(.SAMPLE_BITS(SAMPLE_BITS)) u_ema_y (
    .clk    (clk),
    .rst    (rst),
    .go     (ema_go),
    .seed   (!seeded),
    .raw    (s_tdata[TIME_W+RAW_BITS +: RAW_BITS]),
    .weight (weight),
    .busy   (ema_busy_y),
    .value  (smooth_y)
  );

  chf_cordic #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_go),
    .x_in    (smooth_x),
    .y_in    (smooth_y),
    .busy    (cordic_busy),
    .heading (cd_heading),
    .sector  (cd_sector)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_xact) state_next = do_update ? ST_EMA : ST_DONE;
      ST_EMA:    if (!ema_busy_x) state_next = ST_CORDIC;
      ST_CORDIC: if (!cordic_busy) state_next = ST_DONE;
      ST_DONE:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    cordic_go = 1'b0;
    hold_load = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:   s_tready  = 1'b1;
      ST_EMA:    cordic_go = !ema_busy_x;
      ST_CORDIC: hold_load = !cordic_busy;
      ST_DONE:   out_load  = !m_tvalid || m_tready;
      default:   s_tready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      enable       <= 1'b0;
      weight       <= WEIGHT_RESET;
      min_interval <= INTERVAL_RESET;
      last_time    <= '0;
      seeded       <= 1'b0;
      held_heading <= '0;
      held_sector  <= '0;
      updated      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_addr)
          REG_ENABLE:   enable       <= cfg_wdata[0];
          REG_WEIGHT:   weight       <= cfg_wdata;
          REG_INTERVAL: min_interval <= cfg_wdata;
          default:      ;
        endcase
      end
      if (in_xact) begin
        updated <= do_update;
        if (time_ok) last_time <= now;
        if (do_update) seeded <= 1'b1;
      end
      if (hold_load) begin
        held_heading <= cd_heading;
        held_sector  <= cd_sector;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {PAD_W'(0), held_sector, held_heading};
      m_tuser <= updated;
    end
  end

`ifndef SYNTHESIS
  a_busy_stays_out: assert property (@(posedge clk) disable iff (rst)
    in_xact |=> !s_tready)
    else $error("input taken while a transaction is in progress");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    ema_busy_x == ema_busy_y)
    else $error("smoothing lanes out of step");

  a_update_needs_seed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> seeded)
    else $error("updated heading without seeded state");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[HEAD_W-1:0] < HEAD_W'(FULL_TURN))
    else $error("heading out of range");

  a_sector_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[HEAD_W +: SECTOR_W] == sector_of(m_tdata[HEAD_W-1:0]))
    else $error("sector does not match heading");
`endif

endmodule

`default_nettype wire

### tb/compass_heading_filter_tb.sv
// Stream testbench for compass_heading_filter: timed magnetometer readings in, headings checked.
module compass_heading_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chf_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASES         = 9;

  typedef struct packed {
    logic [HEAD_W-1:0]   heading;
    logic [SECTOR_W-1:0] sector;
    logic                updated;
  } heading_t;

  class heading_scoreboard;
    logic                enable;
    logic [CFG_W-1:0]    weight;
    logic [CFG_W-1:0]    interval;
    longint              smooth_x;
    longint              smooth_y;
    bit                  seeded;
    logic [TIME_W-1:0]   last_tick;
    logic [HEAD_W-1:0]   held_heading;
    logic [SECTOR_W-1:0] held_sector;
    heading_t            expected_headings[$];
    int                  errors;

    function new();
      enable       = 1'b0;
      weight       = WEIGHT_RESET;
      interval     = INTERVAL_RESET;
      smooth_x     = 0;
      smooth_y     = 0;
      seeded       = 1'b0;
      last_tick    = '0;
      held_heading = '0;
      held_sector  = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_ENABLE:   enable = val[0];
        REG_WEIGHT:   weight = val;
        REG_INTERVAL: interval = val;
        default: ;
      endcase
    endfunction

    function longint ema(longint m, longint sample, longint w);
      return m + ((((sample <<< FRAC_BITS) - m) * w + ROUND_HALF) >>> ROUND_SHIFT);
    endfunction

    function logic [HEAD_W-1:0] cordic_heading(longint x, longint y);
      longint ang;
      longint dx;
      longint dy;
      longint a;
      longint h;
      if (x == 0 && y == 0) return '0;
      ang = 0;
      if (x < 0) begin
        x   = -x;
        y   = -y;
        ang = HALF_TURN_FINE;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        a  = (i < ATAN_ENTRIES) ? longint'(ATAN_FINE[i]) : 0;
        if (y > 0) begin
          x   += dx;
          y   -= dy;
          ang += a;
        end else begin
          x   -= dx;
          y   += dy;
          ang -= a;
        end
      end
      h = (ang + ANGLE_ROUND) >>> ANGLE_SHIFT;
      while (h < 0) h += FULL_TURN;
      while (h >= FULL_TURN) h -= FULL_TURN;
      return HEAD_W'(h);
    endfunction

    function logic [SECTOR_W-1:0] compass_sector(logic [HEAD_W-1:0] h);
      if (h < SECTOR_FIRST || h >= SECTOR_WRAP) return '0;
      return SECTOR_W'((h - SECTOR_FIRST) / SECTOR_SPAN + 1);
    endfunction

    function void note_reading(input logic [TIME_W-1:0] tick,
                               input logic signed [RAW_BITS-1:0] mx,
                               input logic signed [RAW_BITS-1:0] my,
                               input logic ok);
      logic [TIME_W-1:0] delta;
      longint            w;
      heading_t          want;
      want.updated = 1'b0;
      delta = tick - last_tick;
      if (enable && delta >= interval) begin
        last_tick = tick;
        if (ok) begin
          w = (weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight);
          if (!seeded) begin
            smooth_x = longint'(mx) <<< FRAC_BITS;
            smooth_y = longint'(my) <<< FRAC_BITS;
            seeded   = 1'b1;
          end else begin
            smooth_x = ema(smooth_x, longint'(mx), w);
            smooth_y = ema(smooth_y, longint'(my), w);
          end
          held_heading = cordic_heading(smooth_x, smooth_y);
          held_sector  = compass_sector(held_heading);
          want.updated = 1'b1;
        end
      end
      want.heading = held_heading;
      want.sector  = held_sector;
      expected_headings.push_back(want);
    endfunction

    function void check_heading(logic [OUT_TDATA_W-1:0] data, logic upd);
      heading_t want;
      if (expected_headings.size() == 0) begin
        $error("unexpected result transaction: heading %0d", data[HEAD_W-1:0]);
        errors++;
        return;
      end
      want = expected_headings.pop_front();
      if (data[HEAD_W-1:0] !== want.heading) begin
        $error("heading mismatch: expected %0d, actual %0d", want.heading, data[HEAD_W-1:0]);
        errors++;
      end
      if (data[HEAD_W +: SECTOR_W] !== want.sector) begin
        $error("sector mismatch: expected %0d, actual %0d", want.sector,
               data[HEAD_W +: SECTOR_W]);
        errors++;
      end
      if (upd !== want.updated) begin
        $error("updated mismatch: expected %0d, actual %0d", want.updated, upd);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [REG_IDX_W-1:0]   cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // time_ms[31:0], mag_x[47:32], mag_y[63:48]
  logic                   s_tuser;   // read_ok
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // heading[14:0], sector[17:15], zero pad
  logic                   m_tuser;   // updated

  heading_scoreboard sb = new();
  bit                idle_on;
  bit                hold_req;
  logic [TIME_W-1:0] last_sent;
  int                base_x;
  int                base_y;

  compass_heading_filter DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_heading(m_tdata, m_tuser);
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int burst;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        burst = $urandom_range(1, 7);
        repeat (burst - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (sb.expected_headings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_reading(input logic [TIME_W-1:0] tick,
                              input logic signed [RAW_BITS-1:0] mx,
                              input logic signed [RAW_BITS-1:0] my,
                              input logic ok);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {my, mx, tick};
    s_tuser  = ok;
    do @(posedge clk); while (!s_tready);
    sb.note_reading(tick, mx, my, ok);
    last_sent = tick;
    @(negedge clk);
  endtask

  function automatic logic signed [RAW_BITS-1:0] extreme_sample();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  task automatic random_reading();
    logic [TIME_W-1:0]           tick;
    logic signed [RAW_BITS-1:0]  mx;
    logic signed [RAW_BITS-1:0]  my;
    int                          sel;
    sel = $urandom_range(0, 99);
    if (sel < 55)      tick = sb.last_tick + sb.interval + $urandom_range(0, 40);
    else if (sel < 65) tick = sb.last_tick + sb.interval;
    else if (sel < 75) tick = sb.last_tick + sb.interval - 1;
    else if (sel < 90) tick = last_sent + $urandom_range(0, 150);
    else               tick = $urandom();
    if ($urandom_range(0, 49) == 0) begin
      base_x = int'($urandom_range(0, 60000)) - 30000;
      base_y = int'($urandom_range(0, 60000)) - 30000;
    end
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      // steady field with noise, so the average settles on a heading
      mx = RAW_BITS'(base_x + int'($urandom_range(0, 1024)) - 512);
      my = RAW_BITS'(base_y + int'($urandom_range(0, 1024)) - 512);
    end else if (sel < 9) begin
      mx = RAW_BITS'($urandom());
      my = RAW_BITS'($urandom());
    end else begin
      mx = extreme_sample();
      my = extreme_sample();
    end
    send_reading(tick, mx, my, $urandom_range(0, 9) != 0);
  endtask

  initial begin
    logic             en;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] iv;
    int               n;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = REG_ENABLE;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    last_sent = '0;
    base_x    = 12000;
    base_y    = -7000;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // disabled after reset, then early ticks, zero-vector seed, failed read
    send_reading(32'd500, 16'sd1000, 16'sd1000, 1'b1);
    wait_idle();
    write_reg(REG_ENABLE, 16'd1);
    send_reading(32'd50, 16'sd100, 16'sd200, 1'b1);
    send_reading(32'd99, 16'sd100, 16'sd200, 1'b1);
    send_reading(32'd100, 16'sd0, 16'sd0, 1'b1);
    send_reading(32'd150, 16'sd5, 16'sd5, 1'b1);
    send_reading(32'd200, 16'sd300, -16'sd400, 1'b0);
    send_reading(32'd300, 16'sd300, -16'sd400, 1'b1);

    // full weight, no interval: heading follows each sample exactly
    wait_idle();
    write_reg(REG_WEIGHT, WEIGHT_ONE);
    write_reg(REG_INTERVAL, 16'd0);
    send_reading(32'd301, 16'sh7FFF, 16'sh0000, 1'b1);
    send_reading(32'd301, 16'sh0000, 16'sh7FFF, 1'b1);
    send_reading(32'd302, 16'sh8000, 16'sh0000, 1'b1);
    send_reading(32'd303, 16'sh0000, 16'sh8000, 1'b1);
    send_reading(32'd304, 16'sh8000, 16'sh8000, 1'b1);
    send_reading(32'd305, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_reading(32'd306, 16'sh7FFF, 16'sh8000, 1'b1);
    send_reading(32'd307, 16'sh8000, 16'sh7FFF, 1'b1);
    send_reading(32'd308, 16'shFFFF, 16'sh0000, 1'b1);
    send_reading(32'd309, 16'sh0000, 16'sh0000, 1'b1);
    send_reading(32'd310, 16'sh0000, 16'sh0001, 1'b1);
    send_reading(32'd311, 16'sh1234, -16'sd2222, 1'b0);

    // weight above one is clamped; weight zero freezes the average
    wait_idle();
    write_reg(REG_WEIGHT, 16'hFFFF);
    send_reading(32'd400, -16'sd9000, 16'sd3000, 1'b1);
    wait_idle();
    write_reg(REG_WEIGHT, 16'd0);
    send_reading(32'd500, -16'sd5000, 16'sd7000, 1'b1);

    // tick difference across the 32-bit wrap
    wait_idle();
    write_reg(REG_WEIGHT, 16'd1);
    write_reg(REG_INTERVAL, 16'd64);
    send_reading(32'hFFFF_FFC0, 16'sd20000, 16'sd20000, 1'b1);
    send_reading(32'h0000_0010, -16'sd20000, 16'sd20000, 1'b1);
    send_reading(32'h0000_0040, 16'sd1, 16'sd1, 1'b1);

    wait_idle();
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_INTERVAL, 16'hFFFF);
    send_reading(32'h0001_000F, 16'sd4000, -16'sd4000, 1'b1);
    send_reading(32'h0002_000D, 16'sd4000, -16'sd4000, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      en = 1'b1;
      n  = 155;
      case (p)
        0: begin wv = WEIGHT_RESET; iv = INTERVAL_RESET; end
        1: begin wv = 16'd0;        iv = 16'd0; end
        2: begin wv = WEIGHT_ONE;   iv = 16'd1; end
        3: begin wv = 16'hFFFF;     iv = 16'd50; end
        4: begin en = 1'b0; wv = 16'd1000; iv = 16'd10; n = 40; end
        5: begin
          wv = CFG_W'($urandom_range(0, 65535));
          iv = CFG_W'($urandom_range(0, 300));
        end
        6: begin wv = 16'd16384;    iv = 16'hFFFF; end
        7: begin wv = 16'd1;        iv = 16'd0; end
        default: begin
          wv = CFG_W'($urandom_range(0, 32768));
          iv = CFG_W'($urandom_range(0, 200));
          idle_on = 1'b0;
        end
      endcase
      write_reg(REG_ENABLE, {15'd0, en});
      write_reg(REG_WEIGHT, wv);
      write_reg(REG_INTERVAL, iv);
      if (p == 7) write_reg(REG_UNUSED, CFG_W'($urandom()));
      if (p == 2) hold_req = 1'b1;
      repeat (n) random_reading();
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_headings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
